[hdl/prrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package prrd_pkg;
    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

[hdl/prrd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface prrd_in_if #(
    parameter int HB = 8,
    parameter int PB = 3
) ();
    logic          valid;
    logic          ready;
    logic          op;
    logic [HB-1:0] task_handle;
    logic [PB-1:0] task_priority;
    logic          keep_after_run;
    modport source(output valid, op, task_handle, task_priority, keep_after_run, input ready);
    modport sink(input valid, op, task_handle, task_priority, keep_after_run, output ready);
endinterface

interface prrd_out_if #(
    parameter int HB = 8,
    parameter int CB = 5
) ();
    logic              valid;
    logic              ready;
    logic              dispatched;
    logic [HB-1:0]     run_handle;
    logic              round_done;
    logic [CB-1:0]     entries_held;
    prrd_pkg::t_status status;
    modport source(output valid, dispatched, run_handle, round_done, entries_held, status,
                   input ready);
    modport sink(input valid, dispatched, run_handle, round_done, entries_held, status,
                 output ready);
endinterface
`default_nettype wire

[hdl/priority_round_robin_dispatcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// insert: entries of higher priority value are shifted up one by one, then the new task is written in the gap
// dispatch: a kept task stays and the cursor moves on; a one-shot task is removed, the entries behind it closed up
// the walk over the task ram, with one read and one write port, sets the rate; one item at a time
// result goes from the done state into the output registers, waiting while the last is untaken, and is held until taken
// synchronous reset empties the table and sets the cursor to the head, no clearing pass
module priority_round_robin_dispatcher #(
    parameter int TABLE_DEPTH   = 16,
    parameter int HANDLE_BITS   = 8,
    parameter int PRIORITY_BITS = 3
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    prrd_in_if.sink   i_task,
    prrd_out_if.source o_res
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int W  = HANDLE_BITS + PRIORITY_BITS + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_RD = 3'd1;
    localparam logic [2:0] S_INS_WR = 3'd2;
    localparam logic [2:0] S_DSP_WR = 3'd3;
    localparam logic [2:0] S_SH_RD  = 3'd4;
    localparam logic [2:0] S_SH_WR  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]               r_state, n_state;
    logic [CW-1:0]            r_fill, n_fill;
    logic [AW-1:0]            r_cursor, n_cursor;
    logic [CW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_cur, n_cur;
    logic [HANDLE_BITS-1:0]   r_handle, n_handle;
    logic [PRIORITY_BITS-1:0] r_prio, n_prio;
    logic                     r_keep, n_keep;
    logic                     r_p_disp, n_p_disp;
    logic [HANDLE_BITS-1:0]   r_p_run, n_p_run;
    logic                     r_p_wrap, n_p_wrap;
    prrd_pkg::t_status        r_p_status, n_p_status;
    logic                     r_ov, n_ov;
    logic                     r_o_disp;
    logic [HANDLE_BITS-1:0]   r_o_run;
    logic                     r_o_wrap;
    logic [CW-1:0]            r_o_held;
    prrd_pkg::t_status        r_o_status;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, ram_rdata;
    logic          ins_fin;
    logic [CW-1:0] ins_pos, idx_dec, idx_inc, nxt, nf;
    logic          load_out;

    prrd_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_task.ready       = (r_state == S_IDLE);
    assign o_res.valid        = r_ov;
    assign o_res.dispatched   = r_o_disp;
    assign o_res.run_handle   = r_o_run;
    assign o_res.round_done   = r_o_wrap;
    assign o_res.entries_held = r_o_held;
    assign o_res.status       = r_o_status;

    assign idx_dec = r_idx - 1'b1;
    assign idx_inc = r_idx + 1'b1;
    assign nxt     = CW'(r_cur) + 1'b1;
    assign nf      = r_fill - 1'b1;

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cursor   = r_cursor;
        n_idx      = r_idx;
        n_cur      = r_cur;
        n_handle   = r_handle;
        n_prio     = r_prio;
        n_keep     = r_keep;
        n_p_disp   = r_p_disp;
        n_p_run    = r_p_run;
        n_p_wrap   = r_p_wrap;
        n_p_status = r_p_status;
        n_ov       = r_ov;
        load_out   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wdata  = {r_keep, r_prio, r_handle};
        ram_raddr  = '0;
        ins_fin    = 1'b0;
        ins_pos    = r_idx;
        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_task.valid) begin
                    n_handle   = i_task.task_handle;
                    n_prio     = i_task.task_priority;
                    n_keep     = i_task.keep_after_run;
                    n_p_disp   = 1'b0;
                    n_p_run    = '0;
                    n_p_wrap   = 1'b0;
                    n_p_status = prrd_pkg::ST_OK;
                    if (i_task.op == prrd_pkg::OP_INSERT) begin
                        if (r_fill == CW'(TABLE_DEPTH)) begin
                            n_p_status = prrd_pkg::ST_FULL;
                            n_state    = S_DONE;
                        end else begin
                            n_idx   = r_fill;
                            n_state = S_INS_RD;
                        end
                    end else if (r_fill == '0) begin
                        n_cursor   = '0;
                        n_p_status = prrd_pkg::ST_EMPTY;
                        n_state    = S_DONE;
                    end else begin
                        n_cur     = (CW'(r_cursor) >= r_fill) ? '0 : r_cursor;
                        n_idx     = CW'(n_cur);
                        ram_raddr = n_cur;
                        n_state   = S_DSP_WR;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we  = 1'b1;
                    ins_fin = 1'b1;
                end else begin
                    ram_raddr = idx_dec[AW-1:0];
                    n_state   = S_INS_WR;
                end
            end
            S_INS_WR: begin
                ram_we = 1'b1;
                if (ram_rdata[HANDLE_BITS +: PRIORITY_BITS] > r_prio) begin
                    ram_wdata = ram_rdata;
                    n_idx     = idx_dec;
                    n_state   = S_INS_RD;
                end else begin
                    ins_fin = 1'b1;
                end
            end
            S_DSP_WR: begin
                n_p_run  = ram_rdata[HANDLE_BITS-1:0];
                n_p_disp = 1'b1;
                if (ram_rdata[W-1]) begin
                    if (nxt >= r_fill) begin
                        n_cursor = '0;
                        n_p_wrap = 1'b1;
                    end else begin
                        n_cursor = nxt[AW-1:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (idx_inc < r_fill) begin
                    ram_raddr = idx_inc[AW-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_fill = nf;
                    if (CW'(r_cur) >= nf) begin
                        n_cursor = '0;
                        n_p_wrap = 1'b1;
                    end else begin
                        n_cursor = r_cur;
                    end
                    n_state = S_DONE;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = idx_inc;
                n_state   = S_SH_RD;
            end
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (ins_fin) begin
            n_fill = r_fill + 1'b1;
            if (r_fill == '0) begin
                n_cursor = '0;
            end else if (ins_pos <= CW'(r_cursor)) begin
                n_cursor = r_cursor + 1'b1;
            end
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_cursor <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_cursor <= n_cursor;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cur      <= n_cur;
        r_handle   <= n_handle;
        r_prio     <= n_prio;
        r_keep     <= n_keep;
        r_p_disp   <= n_p_disp;
        r_p_run    <= n_p_run;
        r_p_wrap   <= n_p_wrap;
        r_p_status <= n_p_status;
        if (load_out) begin
            r_o_disp   <= r_p_disp;
            r_o_run    <= r_p_run;
            r_o_wrap   <= r_p_wrap;
            r_o_held   <= r_fill;
            r_o_status <= r_p_status;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_cursor_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_fill != '0) |-> (CW'(r_cursor) < r_fill))
        else $error("cursor outside live entries");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill == $past(r_fill) || r_fill == $past(r_fill) + 1'b1
                            || r_fill == $past(r_fill) - 1'b1))
        else $error("fill count jumped");
endmodule
`default_nettype wire

[hdl/prrd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module prrd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    localparam int DEPTH = 16;

    typedef struct packed {
        logic              dispatched;
        logic [7:0]        run_handle;
        logic              round_done;
        logic [4:0]        entries_held;
        prrd_pkg::t_status status;
    } t_result;

    class task_table_board;
        logic [7:0] handles[DEPTH];
        logic [2:0] prios[DEPTH];
        logic       keeps[DEPTH];
        int         fill;
        int         cursor;
        t_result    pending[$];
        int         errors;
        int         reported;

        function new();
            fill = 0;
            cursor = 0;
            errors = 0;
            reported = 0;
        endfunction

        function void note_item(logic op, logic [7:0] h, logic [2:0] p, logic k);
            t_result r;
            int pos;
            int cur;
            int nxt;
            r = '0;
            if (op == prrd_pkg::OP_INSERT) begin
                if (fill >= DEPTH) begin
                    r.status = prrd_pkg::ST_FULL;
                end else begin
                    pos = fill;
                    for (int i = 0; i < fill; i++) begin
                        if (prios[i] > p) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = fill; i > pos; i--) begin
                        handles[i] = handles[i-1];
                        prios[i] = prios[i-1];
                        keeps[i] = keeps[i-1];
                    end
                    handles[pos] = h;
                    prios[pos] = p;
                    keeps[pos] = k;
                    if (fill == 0) cursor = 0;
                    else if (pos <= cursor) cursor++;
                    fill++;
                    r.status = prrd_pkg::ST_OK;
                end
            end else begin
                if (fill == 0) begin
                    cursor = 0;
                    r.status = prrd_pkg::ST_EMPTY;
                end else begin
                    cur = (cursor >= fill) ? 0 : cursor;
                    r.dispatched = 1'b1;
                    r.run_handle = handles[cur];
                    if (!keeps[cur]) begin
                        for (int i = cur; i + 1 < fill; i++) begin
                            handles[i] = handles[i+1];
                            prios[i] = prios[i+1];
                            keeps[i] = keeps[i+1];
                        end
                        fill--;
                        nxt = cur;
                    end else begin
                        nxt = cur + 1;
                    end
                    if (nxt >= fill) begin
                        nxt = 0;
                        r.round_done = 1'b1;
                    end
                    cursor = nxt;
                    r.status = prrd_pkg::ST_OK;
                end
            end
            r.entries_held = fill[4:0];
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result %p", got);
                end
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    task_table_board board;

    prrd_in_if  #(.HB(8), .PB(3)) task_ch ();
    prrd_out_if #(.HB(8), .CB(5)) res_ch ();

    priority_round_robin_dispatcher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_ch.sink),
        .o_res   (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        task_ch.valid = 1'b0;
        task_ch.op = 1'b0;
        task_ch.task_handle = '0;
        task_ch.task_priority = '0;
        task_ch.keep_after_run = 1'b0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result({res_ch.dispatched, res_ch.run_handle, res_ch.round_done,
                                res_ch.entries_held, res_ch.status});
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(logic op, logic [7:0] h, logic [2:0] p, logic k);
        while ($urandom_range(99) < send_idle_pct) begin
            task_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        task_ch.valid <= 1'b1;
        task_ch.op <= op;
        task_ch.task_handle <= h;
        task_ch.task_priority <= p;
        task_ch.keep_after_run <= k;
        do @(posedge i_clk); while (!task_ch.ready);
        board.note_item(op, h, p, k);
    endtask

    task automatic send_random(int n);
        logic op;
        for (int i = 0; i < n; i++) begin
            // lean toward inserts when the table is low, dispatches when high
            if (board.fill < 4) op = ($urandom_range(99) < 30);
            else if (board.fill > 13) op = ($urandom_range(99) < 70);
            else op = 1'($urandom_range(1));
            send_item(op, 8'($urandom), 3'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        task_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty dispatch, fill past full, mixed priorities, dispatches from a full table
        send_item(prrd_pkg::OP_DISPATCH, 8'hff, 3'd7, 1'b1);
        send_item(prrd_pkg::OP_INSERT, 8'h00, 3'd0, 1'b1);
        send_item(prrd_pkg::OP_INSERT, 8'hff, 3'd7, 1'b0);
        send_item(prrd_pkg::OP_INSERT, 8'h55, 3'd0, 1'b0);
        send_item(prrd_pkg::OP_DISPATCH, 8'h00, 3'd0, 1'b0);
        send_item(prrd_pkg::OP_INSERT, 8'haa, 3'd0, 1'b1);
        for (int i = 0; i < 12; i++)
            send_item(prrd_pkg::OP_INSERT, 8'(i + 16), 3'(i % 8), 1'(i % 2));
        send_item(prrd_pkg::OP_INSERT, 8'h77, 3'd3, 1'b1);
        for (int i = 0; i < 5; i++)
            send_item(prrd_pkg::OP_DISPATCH, 8'h00, 3'd0, 1'b0);
        wait_drained();
        send_idle_pct = 32;
        recv_idle_pct = 45;
        send_random(600);
        wait_drained();
        send_idle_pct = 45;
        recv_idle_pct = 32;
        send_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(600);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
